/* rtl/assert_macros.svh */
// Assertion macros used by the translator controller (tft_ctrl).
// Depends on nothing; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/tft_pkg.sv */
// Package for the TLB address translator: widths, payload structs, states.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package tft_pkg;
	localparam int ADDR_W      = 32;
	localparam int FRAME_W     = 16;
	localparam int OFF_W       = 16;
	localparam int PS_W        = 17;
	localparam int NP_W        = 9;
	localparam int CNT_W       = 32;
	localparam int TLB_ENTRIES = 4;
	localparam int TLB_IW      = $clog2(TLB_ENTRIES);
	localparam int PAGES       = 256;
	localparam int PT_AW       = $clog2(PAGES);
	localparam int DIV_STEPS   = ADDR_W;
	localparam int DIV_CW      = $clog2(DIV_STEPS);
	localparam int CFG_IW      = 1;
	localparam int CFG_DW      = PS_W;

	localparam logic [PS_W-1:0] PS_RESET = PS_W'(4096);
	localparam logic [PS_W-1:0] PS_MAX   = PS_W'(65536);
	localparam logic [NP_W-1:0] NP_RESET = NP_W'(4);
	localparam logic [NP_W-1:0] NP_MAX   = NP_W'(PAGES);

	localparam logic [CFG_IW-1:0] REG_PAGE_SIZE = 1'b0;
	localparam logic [CFG_IW-1:0] REG_NUM_PAGES = 1'b1;

	localparam logic REQ_TRANSLATE = 1'b0;
	localparam logic REQ_WRITE     = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic [ADDR_W-1:0]  logical_address;
		logic [PT_AW-1:0]   entry_index;
		logic [FRAME_W-1:0] entry_frame;
	} req_t;

	typedef struct packed {
		logic               tlb_hit;
		logic               address_valid;
		logic [ADDR_W-1:0]  page_number;
		logic [OFF_W-1:0]   page_offset;
		logic [FRAME_W-1:0] frame;
		logic [ADDR_W-1:0]  physical_address;
		logic [CNT_W-1:0]   hit_count;
		logic [CNT_W-1:0]   miss_count;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_LOOK,
		ST_READ,
		ST_MUL,
		ST_FIN,
		ST_WRITE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic lookup;
		logic update;
		logic mul;
		logic fin;
		logic write;
	} cmd_t;

	typedef struct packed {
		logic in_write;
	} sts_t;
endpackage

/* rtl/tft_ctrl.sv */
// Controller FSM of the translator: sequences divide, lookup, table read,
// multiply, result or table write. Depends on tft_pkg, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tft_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  tft_pkg::sts_t sts,
	output tft_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done
);
	import tft_pkg::*;

	state_t             state_q;
	state_t             state_nxt;
	logic [DIV_CW-1:0]  cnt_q;
	logic               last;

	assign last = (cnt_q == DIV_CW'(DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nxt = sts.in_write ? ST_WRITE : ST_DIV;
				end
			end
			ST_DIV: begin
				if (last) begin
					state_nxt = ST_LOOK;
				end
			end
			ST_LOOK:  state_nxt = ST_READ;
			ST_READ:  state_nxt = ST_MUL;
			ST_MUL:   state_nxt = ST_FIN;
			ST_FIN:   state_nxt = ST_DONE;
			ST_WRITE: state_nxt = ST_DONE;
			ST_DONE:  state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.load = (state_q == ST_IDLE) && start;
		unique case (state_q)
			ST_DIV:   cmd.div_step = 1'b1;
			ST_LOOK:  cmd.lookup   = 1'b1;
			ST_READ:  cmd.update   = 1'b1;
			ST_MUL:   cmd.mul      = 1'b1;
			ST_FIN:   cmd.fin      = 1'b1;
			ST_WRITE: cmd.write    = 1'b1;
			default:  cmd.div_step = 1'b0;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

	`ASSERT_NXT(a_done_one_cycle, clk, arst_n, done, !done)
	`ASSERT_NXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`ASSERT_NXT(a_div_exit, clk, arst_n, (state_q == ST_DIV) && last, state_q == ST_LOOK)
	`ASSERT_IMP(a_done_busy, clk, arst_n, done, busy)
endmodule

/* rtl/tft_dp.sv */
// Datapath of the translator: config registers, radix-2 divider, TLB,
// page table memory, multiplier, counters and result register. Uses tft_pkg.
`timescale 1ns / 1ps
module tft_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tft_pkg::cmd_t                cmd,
	output tft_pkg::sts_t                sts,
	input  tft_pkg::req_t                req,
	output tft_pkg::rsp_t                rsp,
	input  logic                         cfg_we,
	input  logic [tft_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [tft_pkg::CFG_DW-1:0]   cfg_data
);
	import tft_pkg::*;

	logic [PS_W-1:0]    page_size_q;
	logic [NP_W-1:0]    num_pages_q;
	logic [PS_W-1:0]    ps_eff;
	logic [NP_W-1:0]    np_eff;

	req_t               req_q;
	logic [PS_W-1:0]    ps_q;
	logic [NP_W-1:0]    np_q;
	logic [OFF_W-1:0]   rem_q;
	logic [ADDR_W-1:0]  quo_q;
	logic [PS_W-1:0]    sh;
	logic [PS_W-1:0]    diff;
	logic               ge;

	logic               tlb_vld_q [TLB_ENTRIES];
	logic [PT_AW-1:0]   tlb_page_q [TLB_ENTRIES];
	logic [FRAME_W-1:0] tlb_frm_q [TLB_ENTRIES];
	logic [TLB_IW-1:0]  fill_q;
	logic               hit_c;
	logic [FRAME_W-1:0] hfrm_c;
	logic               valid_c;

	logic [FRAME_W-1:0] pt_mem [PAGES];
	logic               pt_vld_q [PAGES];
	logic [FRAME_W-1:0] pt_rd_q;
	logic               pt_rd_vld_q;
	logic [FRAME_W-1:0] found;

	logic               hit_q;
	logic               valid_q;
	logic [FRAME_W-1:0] tfrm_q;
	logic [FRAME_W-1:0] frm_q;
	logic [ADDR_W-1:0]  prod_q;
	logic [CNT_W-1:0]   hit_cnt_q;
	logic [CNT_W-1:0]   miss_cnt_q;
	rsp_t               rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q <= PS_RESET;
			num_pages_q <= NP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PAGE_SIZE: page_size_q <= cfg_data;
				REG_NUM_PAGES: num_pages_q <= cfg_data[NP_W-1:0];
				default:       page_size_q <= page_size_q;
			endcase
		end
	end

	always_comb begin
		if (page_size_q == '0) begin
			ps_eff = PS_W'(1);
		end else if (page_size_q > PS_MAX) begin
			ps_eff = PS_MAX;
		end else begin
			ps_eff = page_size_q;
		end
		np_eff = (num_pages_q > NP_MAX) ? NP_MAX : num_pages_q;
	end

	assign sts.in_write = (req.req_type == REQ_WRITE);

	assign sh   = {rem_q, quo_q[ADDR_W-1]};
	assign ge   = (sh >= ps_q);
	assign diff = sh - ps_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
			ps_q  <= ps_eff;
			np_q  <= np_eff;
			rem_q <= '0;
			quo_q <= req.logical_address;
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[OFF_W-1:0] : sh[OFF_W-1:0];
			quo_q <= {quo_q[ADDR_W-2:0], ge};
		end
	end

	always_comb begin
		hit_c  = 1'b0;
		hfrm_c = '0;
		for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
			if (tlb_vld_q[i] && (ADDR_W'(tlb_page_q[i]) == quo_q)) begin
				hit_c  = 1'b1;
				hfrm_c = tlb_frm_q[i];
			end
		end
		valid_c = (quo_q < ADDR_W'(np_q));
	end

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			pt_mem[req_q.entry_index] <= req_q.entry_frame;
		end
		if (cmd.lookup) begin
			pt_rd_q     <= pt_mem[quo_q[PT_AW-1:0]];
			pt_rd_vld_q <= pt_vld_q[quo_q[PT_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PAGES; i++) begin
				pt_vld_q[i] <= 1'b0;
			end
		end else if (cmd.write) begin
			pt_vld_q[req_q.entry_index] <= 1'b1;
		end
	end

	assign found = hit_q ? tfrm_q :
		(pt_rd_vld_q ? pt_rd_q : FRAME_W'(quo_q[PT_AW-1:0]));

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			hit_q   <= hit_c;
			valid_q <= valid_c;
			tfrm_q  <= hfrm_c;
		end
		if (cmd.update) begin
			frm_q <= valid_q ? found : '0;
		end
		if (cmd.mul) begin
			prod_q <= ADDR_W'(frm_q) * ADDR_W'(ps_q);
		end
		if (cmd.update && !hit_q && valid_q) begin
			tlb_page_q[fill_q] <= quo_q[PT_AW-1:0];
			tlb_frm_q[fill_q]  <= found;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TLB_ENTRIES; i++) begin
				tlb_vld_q[i] <= 1'b0;
			end
			fill_q     <= '0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
		end else if (cmd.update) begin
			if (hit_q) begin
				hit_cnt_q <= hit_cnt_q + 1'b1;
			end else begin
				miss_cnt_q <= miss_cnt_q + 1'b1;
				if (valid_q) begin
					tlb_vld_q[fill_q] <= 1'b1;
					fill_q <= (fill_q == TLB_IW'(TLB_ENTRIES - 1)) ? '0 : fill_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			rsp_q.tlb_hit          <= hit_q;
			rsp_q.address_valid    <= valid_q;
			rsp_q.page_number      <= quo_q;
			rsp_q.page_offset      <= rem_q;
			rsp_q.frame            <= frm_q;
			rsp_q.physical_address <= valid_q ?
				(prod_q + ADDR_W'(rem_q)) : '0;
			rsp_q.hit_count        <= hit_cnt_q;
			rsp_q.miss_count       <= miss_cnt_q;
		end else if (cmd.write) begin
			rsp_q            <= '0;
			rsp_q.hit_count  <= hit_cnt_q;
			rsp_q.miss_count <= miss_cnt_q;
		end
	end

	assign rsp = rsp_q;
endmodule

/* rtl/tlb_fifo_address_translator_unit.sv */
// Top level of the TLB address translator: controller plus datapath.
// Depends on tft_pkg, tft_ctrl and tft_dp.
`timescale 1ns / 1ps
// A translate item runs from accept through the radix-2 divider (one
// page-number bit per cycle), then TLB lookup, page-table read, multiply
// and result states, then shows done; a page-table write item goes through
// its write state, then shows done. No new item is taken until the unit is
// idle again after done. The result is on rsp when done is high for its
// single cycle and stays until the next item; the receiver cannot stall it,
// so capture it then. Write configuration only while busy is low.
module tlb_fifo_address_translator_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  tft_pkg::req_t                req,
	output logic                         done,
	output tft_pkg::rsp_t                rsp,
	input  logic                         cfg_we,
	input  logic [tft_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [tft_pkg::CFG_DW-1:0]   cfg_data
);
	import tft_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tft_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	tft_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);
endmodule
